@@ src/two_slot_transposition_table_assert.svh @@
// Assertion macros for the checking file of the transposition table.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TWO_SLOT_TRANSPOSITION_TABLE_ASSERT_SVH
`define TWO_SLOT_TRANSPOSITION_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tstt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tstt: next-cycle check failed");

`endif

@@ src/tstt_pkg.sv @@
package tstt_pkg;

  typedef enum logic [1:0] {
    FN_PROBE = 2'd0,
    FN_STORE = 2'd1,
    FN_AGE   = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  localparam logic [2:0] ST_MISS    = 3'd0;
  localparam logic [2:0] ST_SHALLOW = 3'd1;
  localparam logic [2:0] ST_EXACT   = 3'd2;
  localparam logic [2:0] ST_LOWER   = 3'd3;
  localparam logic [2:0] ST_UPPER   = 3'd4;

  localparam int GEN_W = 6;
  localparam int SIG_W = 32;

  typedef struct packed {
    logic             upper;
    logic             lower;
    logic             exact;
    logic             threat;
    logic [GEN_W-1:0] gen;
  } flags_t;

  // Signature and flags: the part of a slot that a clear wipes.
  typedef struct packed {
    logic [SIG_W-1:0] sig;
    flags_t           flags;
  } tag_t;

  // Move, depth and score: the part of a slot that a clear keeps.
  typedef struct packed {
    logic [15:0]        move;
    logic [7:0]         depth;
    logic signed [15:0] score;
  } body_t;

  localparam int TAG_W  = $bits(tag_t);
  localparam int BODY_W = $bits(body_t);

  typedef struct packed {
    func_t              func;
    logic [63:0]        key;
    logic [7:0]         search_depth;
    logic [7:0]         ply;
    logic signed [15:0] best_score;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        move_in;
    logic               threat_in;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] score_out;
    logic [15:0]        move_out;
    logic               threat_out;
    logic               stored;
  } rsp_t;

  typedef struct packed {
    logic  en;
    logic  second;
    tag_t  tag;
    body_t body;
  } wr_t;

endpackage

@@ src/tstt_if.sv @@
interface tstt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [63:0]        key;
  logic [7:0]         search_depth;
  logic [7:0]         ply;
  logic signed [15:0] best_score;
  logic signed [15:0] alpha;
  logic signed [15:0] beta;
  logic [15:0]        move_in;
  logic               threat_in;

  modport source (
    output valid, func, key, search_depth, ply, best_score, alpha, beta, move_in, threat_in,
    input  ready
  );
  modport sink (
    input  valid, func, key, search_depth, ply, best_score, alpha, beta, move_in, threat_in,
    output ready
  );
endinterface

interface tstt_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] score_out;
  logic [15:0]        move_out;
  logic               threat_out;
  logic               stored;

  modport source (
    output valid, status, score_out, move_out, threat_out, stored,
    input  ready
  );
  modport sink (
    input  valid, status, score_out, move_out, threat_out, stored,
    output ready
  );
endinterface

@@ src/tstt_ram.sv @@
// Synchronous RAM with one write port and two registered read ports.
module tstt_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [W-1:0]  rdata0,
  output logic [W-1:0]  rdata1
);
  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end
endmodule

@@ src/tstt_decide.sv @@
// Evaluates one operation against the two slots of its bucket: builds the
// result and, for a store, the entry and the slot to write.
module tstt_decide (
  input  tstt_pkg::req_t  req,
  input  tstt_pkg::tag_t  tag1,
  input  tstt_pkg::tag_t  tag2,
  input  tstt_pkg::body_t body1,
  input  tstt_pkg::body_t body2,
  input  logic [5:0]      generation,
  input  logic [14:0]     mate_limit,
  output tstt_pkg::rsp_t  rsp,
  output tstt_pkg::wr_t   wr
);
  logic [31:0]        sig;
  logic signed [17:0] lim;
  logic signed [17:0] neg_lim;
  logic signed [17:0] ply_s;
  logic               hit1;
  logic               hit2;
  tstt_pkg::tag_t     h_tag;
  tstt_pkg::body_t    h_body;
  logic signed [17:0] h_sc;
  logic signed [17:0] h_corr;
  logic signed [17:0] best;
  logic signed [17:0] best_corr;
  logic [7:0]         d1;
  logic [7:0]         d2;
  logic [7:0]         dn;
  logic               found;
  logic               second;
  logic [2:0]         bound;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign sig     = req.key[31:0];
  assign lim     = $signed({3'b000, mate_limit});
  assign neg_lim = -lim;
  assign ply_s   = $signed({10'd0, req.ply});
  assign hit1    = (tag1.sig == sig);
  assign hit2    = (tag2.sig == sig);
  assign h_tag   = hit1 ? tag1 : tag2;
  assign h_body  = hit1 ? body1 : body2;
  assign h_sc    = {{2{h_body.score[15]}}, h_body.score};
  assign best    = {{2{req.best_score[15]}}, req.best_score};
  assign d1      = body1.depth;
  assign d2      = body2.depth;
  assign dn      = req.search_depth;

  // Mate scores are stored relative to the node and read back relative to the root.
  always_comb begin
    if (h_sc > lim) begin
      h_corr = h_sc - ply_s;
    end else if (h_sc < neg_lim) begin
      h_corr = h_sc + ply_s;
    end else begin
      h_corr = h_sc;
    end
    if (best > lim) begin
      best_corr = best + ply_s;
    end else if (best < neg_lim) begin
      best_corr = best - ply_s;
    end else begin
      best_corr = best;
    end
  end

  // Replacement: matching slot, then the shallower slot within depth, then a stale slot.
  always_comb begin
    found  = 1'b1;
    second = 1'b0;
    if (hit1) begin
      second = 1'b0;
    end else if (hit2) begin
      second = 1'b1;
    end else if (d1 <= d2) begin
      if (d1 <= dn) begin
        second = 1'b0;
      end else if (d2 <= dn) begin
        second = 1'b1;
      end else begin
        found = 1'b0;
      end
    end else begin
      if (d2 <= dn) begin
        second = 1'b1;
      end else if (d1 <= dn) begin
        second = 1'b0;
      end else begin
        found = 1'b0;
      end
    end
    if (!found) begin
      if (tag1.flags.gen != generation) begin
        found  = 1'b1;
        second = 1'b0;
      end else if (tag2.flags.gen != generation) begin
        found  = 1'b1;
        second = 1'b1;
      end
    end
  end

  // Bound kind as {upper, lower, exact}.
  always_comb begin
    if (req.best_score <= req.alpha) begin
      bound = 3'b100;
    end else if (req.best_score >= req.beta) begin
      bound = 3'b010;
    end else begin
      bound = 3'b001;
    end
  end

  always_comb begin
    wr.en                = (req.func == tstt_pkg::FN_STORE) && found;
    wr.second            = second;
    wr.tag.sig           = sig;
    wr.tag.flags.upper   = bound[2];
    wr.tag.flags.lower   = bound[1];
    wr.tag.flags.exact   = bound[0];
    wr.tag.flags.threat  = req.threat_in;
    wr.tag.flags.gen     = generation;
    wr.body.move         = req.move_in;
    wr.body.depth        = req.search_depth;
    wr.body.score        = sat16(best_corr);
  end

  always_comb begin
    rsp.status     = tstt_pkg::ST_MISS;
    rsp.score_out  = 16'sd0;
    rsp.move_out   = 16'd0;
    rsp.threat_out = 1'b0;
    rsp.stored     = 1'b0;
    case (req.func)
      tstt_pkg::FN_PROBE: begin
        if (hit1 || hit2) begin
          rsp.move_out   = h_body.move;
          rsp.threat_out = h_tag.flags.threat;
          if (h_body.depth >= dn) begin
            if (h_tag.flags.exact) begin
              rsp.status    = tstt_pkg::ST_EXACT;
              rsp.score_out = sat16(h_corr);
            end else if (h_tag.flags.lower) begin
              rsp.status    = tstt_pkg::ST_LOWER;
              rsp.score_out = sat16(h_corr);
            end else if (h_tag.flags.upper) begin
              rsp.status    = tstt_pkg::ST_UPPER;
              rsp.score_out = sat16(h_corr);
            end
          end else begin
            rsp.status = tstt_pkg::ST_SHALLOW;
          end
        end
      end
      tstt_pkg::FN_STORE: begin
        rsp.stored = found;
      end
      default: begin
      end
    endcase
  end
endmodule

@@ src/two_slot_transposition_table.sv @@
// Two-slot transposition table. Each request transaction carries a probe, a
// store, an age step or a clear; each produces exactly one response
// transaction. Key bits [32 +: INDEX_BITS] select a bucket of two adjacent
// slots (the second wraps to slot zero at the table end) and key bits [31:0]
// are the signature. A probe, store or age reads both slots from the two table
// RAMs on acceptance; the eval state, once the response register is free,
// evaluates and, for a store, writes one slot back. A clear does the same and
// then sweeps the signature/flags RAM one slot per cycle, holding off new
// requests until the sweep ends. After reset the same sweep zeroes both RAMs,
// so no request is accepted until it ends. The user writes the mate_limit
// register via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module two_slot_transposition_table #(
  parameter int INDEX_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [14:0]       cfg_wdata,
  tstt_req_if.sink          req,
  tstt_rsp_if.source        rsp
);
  // Sweep zeroes slots, idle waits for a request, eval finishes one request.
  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  localparam logic [INDEX_BITS-1:0] IDX_ONE  = {{(INDEX_BITS-1){1'b0}}, 1'b1};
  localparam logic [INDEX_BITS-1:0] IDX_LAST = {INDEX_BITS{1'b1}};

  state_t                  state;
  logic [INDEX_BITS-1:0]   sweep_cnt;
  logic                    sweep_all;
  logic [5:0]              generation;
  logic [14:0]             mate_limit;
  tstt_pkg::req_t          req_r;
  logic                    rsp_valid;
  tstt_pkg::rsp_t          rsp_r;

  logic                    accept;
  logic                    fire;
  logic [INDEX_BITS-1:0]   raddr1;
  logic [INDEX_BITS-1:0]   raddr2;
  logic [INDEX_BITS-1:0]   idx1;
  logic [INDEX_BITS-1:0]   idx2;
  logic                    we_tag;
  logic                    we_body;
  logic [INDEX_BITS-1:0]   waddr;
  tstt_pkg::tag_t          wtag;
  tstt_pkg::body_t         wbody;
  tstt_pkg::tag_t          tag1;
  tstt_pkg::tag_t          tag2;
  tstt_pkg::body_t         body1;
  tstt_pkg::body_t         body2;
  tstt_pkg::rsp_t          rsp_c;
  tstt_pkg::wr_t           wr;

  // Requests are taken only while idle, so a write from the previous request
  // has always landed before the next read: the FSM is the interlock.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // The response register frees up in the same cycle it is drained.
  assign fire = (state == S_EVAL) && (!rsp_valid || rsp.ready);

  assign raddr1 = req.key[32 +: INDEX_BITS];
  assign raddr2 = raddr1 + IDX_ONE;
  assign idx1   = req_r.key[32 +: INDEX_BITS];
  assign idx2   = idx1 + IDX_ONE;

  // Write port: the sweep owns it in the sweep state, a store in the eval state.
  always_comb begin
    we_tag  = 1'b0;
    we_body = 1'b0;
    waddr   = wr.second ? idx2 : idx1;
    wtag    = wr.tag;
    wbody   = wr.body;
    if (state == S_SWEEP) begin
      we_tag  = 1'b1;
      we_body = sweep_all;
      waddr   = sweep_cnt;
      wtag    = '0;
      wbody   = '0;
    end else if (fire) begin
      we_tag  = wr.en;
      we_body = wr.en;
    end
  end

  tstt_ram #(
    .W  (tstt_pkg::TAG_W),
    .AW (INDEX_BITS)
  ) u_tag_ram (
    .clk    (clk),
    .we     (we_tag),
    .waddr  (waddr),
    .wdata  (wtag),
    .re     (accept),
    .raddr0 (raddr1),
    .raddr1 (raddr2),
    .rdata0 (tag1),
    .rdata1 (tag2)
  );

  tstt_ram #(
    .W  (tstt_pkg::BODY_W),
    .AW (INDEX_BITS)
  ) u_body_ram (
    .clk    (clk),
    .we     (we_body),
    .waddr  (waddr),
    .wdata  (wbody),
    .re     (accept),
    .raddr0 (raddr1),
    .raddr1 (raddr2),
    .rdata0 (body1),
    .rdata1 (body2)
  );

  tstt_decide u_decide (
    .req        (req_r),
    .tag1       (tag1),
    .tag2       (tag2),
    .body1      (body1),
    .body2      (body2),
    .generation (generation),
    .mate_limit (mate_limit),
    .rsp        (rsp_c),
    .wr         (wr)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      sweep_all  <= 1'b1;
      generation <= '0;
      mate_limit <= 15'd30000;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mate_limit <= cfg_wdata;
      end
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + IDX_ONE;
          if (sweep_cnt == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (fire) begin
            if (req_r.func == tstt_pkg::FN_AGE) begin
              generation <= generation + 6'd1;
            end
            // A clear answers first, then wipes signatures and flags only.
            if (req_r.func == tstt_pkg::FN_CLEAR) begin
              state     <= S_SWEEP;
              sweep_cnt <= '0;
              sweep_all <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the request is held for the eval state, the response
  // until the sink takes it.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.func         <= tstt_pkg::func_t'(req.func);
      req_r.key          <= req.key;
      req_r.search_depth <= req.search_depth;
      req_r.ply          <= req.ply;
      req_r.best_score   <= req.best_score;
      req_r.alpha        <= req.alpha;
      req_r.beta         <= req.beta;
      req_r.move_in      <= req.move_in;
      req_r.threat_in    <= req.threat_in;
    end
    if (fire) begin
      rsp_r <= rsp_c;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_r.status;
  assign rsp.score_out  = rsp_r.score_out;
  assign rsp.move_out   = rsp_r.move_out;
  assign rsp.threat_out = rsp_r.threat_out;
  assign rsp.stored     = rsp_r.stored;
endmodule

@@ src/tstt_monitor.sv @@
`include "two_slot_transposition_table_assert.svh"

// Port-level checks on the transposition table.
module tstt_monitor (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [2:0]         status,
  input logic signed [15:0] score_out,
  input logic               stored
);
  // One request at a time: a taken request blocks the next cycle.
  `TSTT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  // A probe status never comes with a store success.
  `TSTT_ASSERT_SAME(a_status_or_stored, rsp_valid && (status != tstt_pkg::ST_MISS), !stored)
  // Without a bound there is no score.
  `TSTT_ASSERT_SAME(a_no_bound_no_score,
    rsp_valid && ((status == tstt_pkg::ST_MISS) || (status == tstt_pkg::ST_SHALLOW)),
    score_out == 16'sd0)
  // A stalled response stays offered.
  `TSTT_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind two_slot_transposition_table tstt_monitor u_tstt_monitor (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .score_out (rsp.score_out),
  .stored    (rsp.stored)
);
